FILE: hdl/usla_pkg.sv
`default_nettype none
package usla_pkg;

   // largest worker estimate and largest change that is reported
   localparam int WORKER_LIMIT = 1024;
   localparam logic [10:0] MAX_N = 11'(WORKER_LIMIT);
   localparam logic signed [12:0] MAX_DIFF = 13'(WORKER_LIMIT);
   localparam logic [13:0] SEARCH_TOP = 14'(10 * WORKER_LIMIT);

   // rate scale: 1000 ms per second times 256 for Q24.8
   localparam logic [17:0] RATE_SCALE = 18'd256000;

   // reciprocal of ten for values below 43690
   localparam logic [15:0] RECIP_TEN = 16'd52429;
   localparam int RECIP_SHIFT = 19;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_VERIFY = 1'b1;

   typedef enum logic [2:0] {
      CSR_CONTENTION = 3'd0,
      CSR_COHERENCY  = 3'd1,
      CSR_WORKER_RATE = 3'd2,
      CSR_RATE_LIMIT = 3'd3,
      CSR_CEILING    = 3'd4,
      CSR_CAPACITY   = 3'd5,
      CSR_WINDOW     = 3'd6,
      CSR_DIVISIONS  = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_THR, S_N1, S_N2, S_RATE, S_P, S_R, S_BA, S_QQ, S_PR,
      S_MID, S_M1, S_M2, S_M3, S_N, S_CMP, S_SHR, S_OUT
   } state_type;

   typedef struct packed {
      logic        operation;
      logic [47:0] now_ms;
      logic [23:0] load_level;
      logic [10:0] current_workers;
   } req_type;

   typedef struct packed {
      logic               arrival_counted;
      logic signed [11:0] worker_change;
      logic [10:0]        estimated_workers;
      logic               limit_reached;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic [6:0] nbits;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

FILE: hdl/usla_chan_if.sv
`default_nettype none
interface usla_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/usla_mul.sv
`default_nettype none
module usla_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire usla_pkg::unit_ctl_type ctl,
   input  wire logic [63:0]           op_a,
   input  wire logic [63:0]           op_b,
   output usla_pkg::unit_sts_type     sts,
   output logic [127:0]               prod
);
   import usla_pkg::*;

   logic         run_ff, run_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] a_ff, a_in;
   logic [63:0]  b_ff, b_in;

   // shift-add, one multiplier bit per cycle, low bit first
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = ctl.nbits;
         acc_in = '0;
         a_in = {64'd0, op_a};
         b_in = op_b;
      end else if (run_ff) begin
         if (cnt_ff == 7'd0) begin
            run_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[126:0], 1'b0};
            b_in = {1'b0, b_ff[63:1]};
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign sts.busy = run_ff;
   assign sts.done = run_ff && (cnt_ff == 7'd0);
   assign prod = acc_ff;

endmodule
`default_nettype wire

FILE: hdl/usla_div.sv
`default_nettype none
module usla_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire usla_pkg::unit_ctl_type ctl,
   input  wire logic [63:0]           op_num,
   input  wire logic [19:0]           op_den,
   output usla_pkg::unit_sts_type     sts,
   output logic [63:0]                quo
);
   import usla_pkg::*;

   logic        run_ff, run_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] quo_ff, quo_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] den_ff, den_in;
   logic [20:0] trial;

   // restoring division, one quotient bit per cycle, high bit first
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      trial = {rem_ff, num_ff[63]};
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = ctl.nbits;
         num_in = op_num << (7'd64 - ctl.nbits);
         quo_in = '0;
         rem_in = '0;
         den_in = op_den;
      end else if (run_ff) begin
         if (cnt_ff == 7'd0) begin
            run_in = 1'b0;
         end else begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 20'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = trial[19:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            num_in = {num_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign sts.busy = run_ff;
   assign sts.done = run_ff && (cnt_ff == 7'd0);
   assign quo = quo_ff;

endmodule
`default_nettype wire

FILE: hdl/usl_worker_autoscaler.sv
// work: an arrival beat runs one 20-step serial divide for the threshold;
// a verify beat runs mostly the root search, each step running up to three products
// through the bit-serial multiplier
// throughput: one beat at a time; the next beat is taken while a result waits at the output
// reset: synchronous, clears the arrival counter and window start, loads register defaults
`default_nettype none
module usl_worker_autoscaler (
   input  wire logic                   clock,
   input  wire logic                   reset,
   usla_chan_if.sink                   req_if,
   usla_chan_if.source                 rsp_if,
   input  wire logic                   csr_we,
   input  wire usla_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_wdata
);
   import usla_pkg::*;

   // configuration registers
   logic [15:0] contention_ff, coherency_ff, capacity_ff;
   logic [31:0] worker_rate_ff, rate_limit_ff;
   logic [10:0] ceiling_ff;
   logic [19:0] window_ff;
   logic [7:0]  divisions_ff;

   // block state and working registers
   state_type   state_ff, state_in;
   logic        launched_ff;
   logic [31:0] count_ff;
   logic [47:0] wstart_ff;
   req_type     item_ff;
   logic [31:0] x_ff;
   logic [47:0] p_ff;
   logic [48:0] r_ff;
   logic [48:0] uq_ff;
   logic        qneg_ff;
   logic [97:0] tmp_ff;
   logic [13:0] lo_ff, hi_ff, k_ff;
   logic [27:0] kk_ff;
   logic [10:0] raw_ff, n_ff;
   logic        lim_ff, counted_ff;
   logic signed [12:0] diff_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   // units
   unit_ctl_type mul_ctl, div_ctl;
   unit_sts_type mul_sts, div_sts;
   logic [63:0]  mul_a, mul_b, div_num;
   logic [19:0]  div_den;
   logic [127:0] mul_prod;
   logic [63:0]  div_quo;

   usla_mul u_mul (
      .clock(clock), .reset(reset), .ctl(mul_ctl), .op_a(mul_a), .op_b(mul_b),
      .sts(mul_sts), .prod(mul_prod)
   );

   usla_div u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl), .op_num(div_num), .op_den(div_den),
      .sts(div_sts), .quo(div_quo)
   );

   // zero registers that act as one
   logic [7:0]  d_eff;
   logic [15:0] b_eff, cap_eff;
   assign d_eff = (divisions_ff == 8'd0) ? 8'd1 : divisions_ff;
   assign b_eff = (coherency_ff == 16'd0) ? 16'd1 : coherency_ff;
   assign cap_eff = (capacity_ff == 16'd0) ? 16'd1 : capacity_ff;

   // coefficient difference b - a as sign and magnitude
   logic [16:0] bma;
   logic [15:0] bma_mag;
   assign bma = {1'b0, b_eff} - {1'b0, contention_ff};
   assign bma_mag = bma[16] ? 16'(-bma) : bma[15:0];

   // scaled constants of the root test
   logic [52:0] q10;
   logic [55:0] r100;
   assign q10 = {uq_ff, 3'b0} + {3'b0, uq_ff, 1'b0};
   assign r100 = {1'b0, r_ff, 6'b0} + {2'b0, r_ff, 5'b0} + {5'b0, r_ff, 2'b0};

   // arrival threshold and test
   logic [27:0] thr;
   logic [47:0] elapsed;
   logic        arr_hit;
   assign thr = div_quo[19:0] * (d_eff - 8'd1);
   assign elapsed = item_ff.now_ms - wstart_ff;
   assign arr_hit = (item_ff.now_ms > wstart_ff) && (elapsed >= 48'(thr));

   // rate checks
   logic lim_hit, x_zero;
   assign lim_hit = (div_quo[57:32] != 26'd0) || (div_quo[31:0] >= rate_limit_ff);
   assign x_zero = (div_quo[57:0] == 58'd0);

   // q from the coefficient product
   logic [47:0] q_base, q_prod;
   logic [48:0] uq_new;
   logic        qneg_new;
   assign q_base = {worker_rate_ff, 16'd0};
   assign q_prod = mul_prod[47:0];
   always_comb begin
      qneg_new = 1'b0;
      if (!bma[16]) begin
         uq_new = {1'b0, q_base} + {1'b0, q_prod};
      end else if (q_base >= q_prod) begin
         uq_new = {1'b0, q_base - q_prod};
      end else begin
         uq_new = {1'b0, q_prod - q_base};
         qneg_new = 1'b1;
      end
   end

   // discriminant and root search tests
   logic disc_fail, q_nonpos, m1_false, m3_ok;
   assign disc_fail = tmp_ff < mul_prod[97:0];
   assign q_nonpos = qneg_ff || (uq_ff == 49'd0);
   assign m1_false = mul_prod[63:0] > {11'd0, q10};
   assign m3_ok = tmp_ff >= {31'd0, mul_prod[66:0]};

   // search midpoint and final ceil of tenths
   logic [13:0] span, mid;
   logic [14:0] tenth_v;
   logic [30:0] tenth_m;
   assign span = hi_ff - lo_ff + 14'd1;
   assign mid = lo_ff + {1'b0, span[13:1]};
   assign tenth_v = {1'b0, lo_ff} + 15'd9;
   assign tenth_m = tenth_v * RECIP_TEN;

   // worker change pieces
   logic signed [12:0] diff_raw;
   logic [26:0] n_cap;
   logic        need_shr;
   logic signed [25:0] shr_diff;
   logic [10:0] n_clamp;
   assign n_clamp = (raw_ff == 11'd0) ? 11'd1 : ((raw_ff > MAX_N) ? MAX_N : raw_ff);
   assign diff_raw = $signed({2'b0, n_ff}) - $signed({2'b0, item_ff.current_workers});
   assign n_cap = n_ff * cap_eff;
   assign need_shr = diff_raw[12] && ({3'b0, item_ff.load_level} > n_cap);
   assign shr_diff = $signed({2'b0, div_quo[23:0]}) - $signed({15'b0, item_ff.current_workers});

   logic signed [12:0] diff_sat;
   assign diff_sat = (diff_ff > MAX_DIFF) ? MAX_DIFF :
                     ((diff_ff < -MAX_DIFF) ? -MAX_DIFF : diff_ff);

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               if (req_if.payload.operation == OP_ARRIVAL) begin
                  state_in = S_THR;
               end else if (req_if.payload.load_level == 24'd0 || window_ff == 20'd0) begin
                  state_in = S_N;
               end else begin
                  state_in = S_N1;
               end
            end
         end
         S_THR: if (div_sts.done) state_in = S_OUT;
         S_N1: if (mul_sts.done) state_in = S_N2;
         S_N2: if (mul_sts.done) state_in = S_RATE;
         S_RATE: begin
            if (div_sts.done) state_in = (lim_hit || x_zero) ? S_N : S_P;
         end
         S_P: if (mul_sts.done) state_in = S_R;
         S_R: if (mul_sts.done) state_in = S_BA;
         S_BA: if (mul_sts.done) state_in = S_QQ;
         S_QQ: if (mul_sts.done) state_in = S_PR;
         S_PR: begin
            if (mul_sts.done) state_in = (disc_fail || q_nonpos) ? S_N : S_MID;
         end
         S_MID: state_in = (lo_ff >= hi_ff) ? S_N : S_M1;
         S_M1: if (mul_sts.done) state_in = m1_false ? S_MID : S_M2;
         S_M2: if (mul_sts.done) state_in = S_M3;
         S_M3: if (mul_sts.done) state_in = S_MID;
         S_N: state_in = S_CMP;
         S_CMP: state_in = need_shr ? S_SHR : S_OUT;
         S_SHR: if (div_sts.done) state_in = S_OUT;
         S_OUT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // unit launches and operands
   always_comb begin
      mul_ctl = '0;
      div_ctl = '0;
      mul_a = '0;
      mul_b = '0;
      div_num = '0;
      div_den = '0;
      case (state_ff)
         S_THR: begin
            div_ctl = '{start: !launched_ff, nbits: 7'd20};
            div_num = {44'd0, window_ff};
            div_den = {12'd0, d_eff};
         end
         S_N1: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd8};
            mul_a = {32'd0, count_ff};
            mul_b = {56'd0, d_eff};
         end
         S_N2: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd18};
            mul_a = {24'd0, tmp_ff[39:0]};
            mul_b = {46'd0, RATE_SCALE};
         end
         S_RATE: begin
            div_ctl = '{start: !launched_ff, nbits: 7'd58};
            div_num = {6'd0, tmp_ff[57:0]};
            div_den = window_ff;
         end
         S_P: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd16};
            mul_a = {32'd0, x_ff[31:0]};
            mul_b = {48'd0, b_eff};
         end
         S_R: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd17};
            mul_a = {32'd0, x_ff[31:0]};
            mul_b = {47'd0, 17'h10000 - {1'b0, contention_ff}};
         end
         S_BA: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd16};
            mul_a = {32'd0, x_ff[31:0]};
            mul_b = {48'd0, bma_mag};
         end
         S_QQ: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd49};
            mul_a = {15'd0, uq_ff};
            mul_b = {15'd0, uq_ff};
         end
         S_PR: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd48};
            mul_a = {13'd0, r_ff, 2'b0};
            mul_b = {16'd0, p_ff};
         end
         S_M1: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd14};
            mul_a = {15'd0, p_ff, 1'b0};
            mul_b = {50'd0, k_ff};
         end
         S_M2: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd28};
            mul_a = {16'd0, p_ff};
            mul_b = {36'd0, kk_ff};
         end
         S_M3: begin
            mul_ctl = '{start: !launched_ff, nbits: 7'd14};
            mul_a = {11'd0, q10};
            mul_b = {50'd0, k_ff};
         end
         S_SHR: begin
            div_ctl = '{start: !launched_ff, nbits: 7'd24};
            div_num = {40'd0, item_ff.load_level};
            div_den = {4'd0, cap_eff};
         end
         default: begin
            mul_ctl = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         launched_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         wstart_ff <= '0;
      end else begin
         state_ff <= state_in;
         launched_ff <= (state_in == state_ff);
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // arrival counting, saturating
         if (state_ff == S_THR && div_sts.done && arr_hit && count_ff != 32'hFFFF_FFFF) begin
            count_ff <= count_ff + 32'd1;
         end
         // verify restarts the window
         if (state_ff == S_OUT && out_free && item_ff.operation == OP_VERIFY) begin
            count_ff <= '0;
            wstart_ff <= item_ff.now_ms;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         contention_ff <= 16'd0;
         coherency_ff <= 16'd1;
         worker_rate_ff <= 32'd256;
         rate_limit_ff <= 32'd256;
         ceiling_ff <= 11'd1;
         capacity_ff <= 16'd1;
         window_ff <= 20'd1000;
         divisions_ff <= 8'd5;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CONTENTION: contention_ff <= csr_wdata[15:0];
            CSR_COHERENCY: coherency_ff <= csr_wdata[15:0];
            CSR_WORKER_RATE: worker_rate_ff <= csr_wdata;
            CSR_RATE_LIMIT: rate_limit_ff <= csr_wdata;
            CSR_CEILING: ceiling_ff <= csr_wdata[10:0];
            CSR_CAPACITY: capacity_ff <= csr_wdata[15:0];
            CSR_WINDOW: window_ff <= csr_wdata[19:0];
            CSR_DIVISIONS: divisions_ff <= csr_wdata[7:0];
            default: contention_ff <= contention_ff;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               item_ff <= req_if.payload;
               counted_ff <= 1'b0;
               diff_ff <= '0;
               n_ff <= '0;
               // a verify with load over a zero window is at the limit at once
               lim_ff <= (req_if.payload.operation == OP_VERIFY)
                         && (req_if.payload.load_level != 24'd0) && (window_ff == 20'd0);
               if (req_if.payload.load_level == 24'd0) begin
                  raw_ff <= 11'd1;
               end else if (window_ff == 20'd0) begin
                  raw_ff <= ceiling_ff;
               end
            end
         end
         S_THR: if (div_sts.done) counted_ff <= arr_hit;
         S_N1: if (mul_sts.done) tmp_ff <= mul_prod[97:0];
         S_N2: if (mul_sts.done) tmp_ff <= mul_prod[97:0];
         S_RATE: begin
            if (div_sts.done) begin
               x_ff <= div_quo[31:0];
               if (lim_hit) begin
                  raw_ff <= ceiling_ff;
                  lim_ff <= 1'b1;
               end else if (x_zero) begin
                  raw_ff <= 11'd1;
               end
            end
         end
         S_P: if (mul_sts.done) p_ff <= mul_prod[47:0];
         S_R: if (mul_sts.done) r_ff <= mul_prod[48:0];
         S_BA: begin
            if (mul_sts.done) begin
               uq_ff <= uq_new;
               qneg_ff <= qneg_new;
            end
         end
         S_QQ: if (mul_sts.done) tmp_ff <= mul_prod[97:0];
         S_PR: begin
            if (mul_sts.done) begin
               lo_ff <= '0;
               hi_ff <= SEARCH_TOP;
               if (disc_fail) begin
                  raw_ff <= ceiling_ff;
               end else if (q_nonpos) begin
                  raw_ff <= 11'd1;
               end
            end
         end
         S_MID: begin
            k_ff <= mid;
            kk_ff <= mid * mid;
            if (lo_ff >= hi_ff) begin
               raw_ff <= tenth_m[RECIP_SHIFT +: 11];
            end
         end
         S_M1: if (mul_sts.done && m1_false) hi_ff <= k_ff - 14'd1;
         S_M2: if (mul_sts.done) tmp_ff <= {21'd0, mul_prod[76:0]} + {42'd0, r100};
         S_M3: begin
            if (mul_sts.done) begin
               if (m3_ok) begin
                  lo_ff <= k_ff;
               end else begin
                  hi_ff <= k_ff - 14'd1;
               end
            end
         end
         S_N: n_ff <= n_clamp;
         S_CMP: diff_ff <= diff_raw;
         S_SHR: begin
            if (div_sts.done) begin
               diff_ff <= (shr_diff > 26'sd0) ? 13'sd0 : 13'(shr_diff);
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_ff.arrival_counted <= counted_ff;
               rsp_ff.worker_change <= 12'(diff_sat);
               rsp_ff.estimated_workers <= n_ff;
               rsp_ff.limit_reached <= lim_ff;
            end
         end
         default: k_ff <= k_ff;
      endcase
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // a counted arrival beat carries no worker figures
   a_arrival_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.arrival_counted |->
         rsp_if.payload.estimated_workers == 11'd0 && rsp_if.payload.worker_change == 12'sd0
         && !rsp_if.payload.limit_reached)
      else $error("arrival result carries worker data");

   // estimate never exceeds the worker limit
   a_est_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.payload.estimated_workers <= MAX_N)
      else $error("estimate above worker limit");

   // the multiplier is only launched when free
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_ctl.start |-> !mul_sts.busy)
      else $error("multiplier launched while busy");

   // an accepted beat closes the input until its work is done
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("second beat taken while busy");

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
   import usla_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_CONTENTION;
   logic [31:0] csr_wdata = '0;

   usla_chan_if #(.payload_type(req_type)) req_ch ();
   usla_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   usl_worker_autoscaler i_dut (
      .clock(clock), .reset(reset), .req_if(req_ch.sink), .rsp_if(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // autoscaler predictor: register copy, window state, expected result queue
   class autoscale_board;
      logic [15:0] contention, coherency, capacity;
      logic [31:0] worker_rate, rate_limit;
      logic [10:0] ceiling;
      logic [19:0] window;
      logic [7:0] divisions;
      logic [31:0] arrivals;
      logic [47:0] window_start;
      rsp_type pending[$];
      int mismatches;

      function void clear_state();
         contention = 16'd0; coherency = 16'd1; worker_rate = 32'd256; rate_limit = 32'd256;
         ceiling = 11'd1; capacity = 16'd1; window = 20'd1000; divisions = 8'd5;
         arrivals = 32'd0; window_start = 48'd0; mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_CONTENTION: contention = v[15:0];
            CSR_COHERENCY: coherency = v[15:0];
            CSR_WORKER_RATE: worker_rate = v;
            CSR_RATE_LIMIT: rate_limit = v;
            CSR_CEILING: ceiling = v[10:0];
            CSR_CAPACITY: capacity = v[15:0];
            CSR_WINDOW: window = v[19:0];
            CSR_DIVISIONS: divisions = v[7:0];
            default: ;
         endcase
      endfunction

      // tenths k at or below the smaller root of p n^2 - q n + r
      function bit under_root(logic [127:0] p, logic [127:0] q, logic [127:0] r,
                              logic [127:0] k);
         if (10 * q < 2 * p * k) return 0;
         return p * k * k + 100 * r >= 10 * q * k;
      endfunction

      function logic [10:0] estimate(output bit lim);
         logic [127:0] d, x, a, b, p, r, uq, lo, hi, mid;
         logic signed [127:0] q;
         lim = 0;
         if (window == 0) begin
            lim = 1;
            return ceiling;
         end
         d = divisions ? divisions : 1;
         a = contention;
         b = coherency ? coherency : 1;
         x = (128'(arrivals) * d * 256000) / window;
         if (x >= rate_limit) begin
            lim = 1;
            return ceiling;
         end
         if (x == 0) return 11'd1;
         p = b * x;
         r = (65536 - a) * x;
         q = $signed(128'(worker_rate) << 16) + ($signed(b) - $signed(a)) * $signed(x);
         uq = q < 0 ? -q : q;
         if (uq * uq < p * 4 * r) return ceiling;
         if (q <= 0) return 11'd1;
         lo = 0;
         hi = 10 * WORKER_LIMIT;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (under_root(p, q, r, mid)) lo = mid;
            else hi = mid - 1;
         end
         return 11'((lo + 9) / 10);
      endfunction

      function void note_request(req_type rq);
         rsp_type e;
         logic [63:0] d, thr, cap, n;
         logic signed [63:0] diff;
         bit lim;
         e = '0;
         d = divisions ? divisions : 1;
         if (rq.operation == OP_ARRIVAL) begin
            thr = (window / d) * (d - 1);
            if (rq.now_ms > window_start && rq.now_ms - window_start >= thr) begin
               if (arrivals != 32'hFFFF_FFFF) arrivals++;
               e.arrival_counted = 1;
            end
         end else begin
            lim = 0;
            cap = capacity ? capacity : 1;
            n = rq.load_level == 0 ? 1 : estimate(lim);
            if (n < 1) n = 1;
            if (n > WORKER_LIMIT) n = WORKER_LIMIT;
            diff = $signed(n) - $signed(64'(rq.current_workers));
            if (diff < 0) begin
               if (rq.load_level > n * cap)
                  diff = $signed(64'(rq.load_level / cap)) - $signed(64'(rq.current_workers));
               if (diff > 0) diff = 0;
            end
            if (diff > WORKER_LIMIT) diff = WORKER_LIMIT;
            if (diff < -WORKER_LIMIT) diff = -WORKER_LIMIT;
            e.worker_change = diff[11:0];
            e.estimated_workers = n[10:0];
            e.limit_reached = lim;
            arrivals = 0;
            window_start = rq.now_ms;
         end
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.arrival_counted !== e.arrival_counted
             || got.worker_change !== e.worker_change
             || got.estimated_workers !== e.estimated_workers
             || got.limit_reached !== e.limit_reached) begin
            mismatches++;
            if (mismatches <= 10) $display("response mismatch: expected %p, got %p", e, got);
         end
      endfunction
   endclass

   autoscale_board board = new();
   bit calm;
   int idle_cycles = 0;
   logic [47:0] clock_ms;

   // response side: random stall, check every accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.payload);
      rsp_ch.ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 32);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic send_beat(req_type rq);
      while (!calm && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= rq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(rq);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic arrival(logic [47:0] t);
      req_type rq;
      rq = '0;
      rq.operation = OP_ARRIVAL;
      rq.now_ms = t;
      rq.load_level = $urandom;
      rq.current_workers = $urandom;
      send_beat(rq);
   endtask

   task automatic verify(logic [47:0] t, logic [23:0] load, logic [10:0] workers);
      req_type rq;
      rq.operation = OP_VERIFY;
      rq.now_ms = t;
      rq.load_level = load;
      rq.current_workers = workers;
      send_beat(rq);
   endtask

   // one window: arrivals spread over the window, then a verify
   task automatic window_run(int count);
      logic [47:0] base;
      base = clock_ms;
      repeat (count) begin
         clock_ms = clock_ms + $urandom_range(board.window / (count + 1) + 1);
         arrival(clock_ms);
      end
      clock_ms = base + board.window + $urandom_range(3);
      case ($urandom_range(3))
         0: verify(clock_ms, 0, $urandom_range(1024));
         1: verify(clock_ms, $urandom_range(64), $urandom_range(1024));
         2: verify(clock_ms, $urandom, $urandom_range(1024));
         default: verify(clock_ms, $urandom_range(5000), $urandom_range(30));
      endcase
   endtask

   task automatic set_profile(int k);
      case (k)
         0: begin
            write_csr(CSR_CONTENTION, 0); write_csr(CSR_COHERENCY, 1);
            write_csr(CSR_WORKER_RATE, 256); write_csr(CSR_RATE_LIMIT, 32'hFFFF_FFFF);
            write_csr(CSR_CEILING, 1024); write_csr(CSR_CAPACITY, 1);
            write_csr(CSR_WINDOW, 100); write_csr(CSR_DIVISIONS, 4);
         end
         1: begin
            write_csr(CSR_CONTENTION, 65535); write_csr(CSR_COHERENCY, 65535);
            write_csr(CSR_WORKER_RATE, 32'hFFFF_FFFF); write_csr(CSR_RATE_LIMIT, 1);
            write_csr(CSR_CEILING, 1); write_csr(CSR_CAPACITY, 65535);
            write_csr(CSR_WINDOW, 1); write_csr(CSR_DIVISIONS, 255);
         end
         2: begin
            write_csr(CSR_CONTENTION, 3000); write_csr(CSR_COHERENCY, 200);
            write_csr(CSR_WORKER_RATE, 2560); write_csr(CSR_RATE_LIMIT, 4000000);
            write_csr(CSR_CEILING, 700); write_csr(CSR_CAPACITY, 20);
            write_csr(CSR_WINDOW, 1000000); write_csr(CSR_DIVISIONS, 1);
         end
         default: begin
            write_csr(CSR_CONTENTION, $urandom_range(65535));
            write_csr(CSR_COHERENCY, $urandom_range(65535));
            write_csr(CSR_WORKER_RATE, $urandom_range(200000, 1));
            write_csr(CSR_RATE_LIMIT, $urandom);
            write_csr(CSR_CEILING, $urandom_range(1024, 1));
            write_csr(CSR_CAPACITY, $urandom_range(65535));
            write_csr(CSR_WINDOW, $urandom_range(2000));
            write_csr(CSR_DIVISIONS, $urandom_range(255));
         end
      endcase
   endtask

   initial begin
      board.clear_state();
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      calm = 1'b0;
      clock_ms = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, edges of the fields, zero and extreme registers
      arrival(0);
      arrival(48'hFFFF_FFFF_FFFF);
      verify(48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 11'd1024);
      arrival(5);
      verify(10, 0, 0);
      drain();
      set_profile(0);
      window_run(0);
      window_run(5);
      window_run(40);
      verify(clock_ms + 1, 24'hFF_FFFF, 0);
      drain();
      set_profile(1);
      window_run(3);
      verify(clock_ms + 7, 1, 1024);
      drain();
      write_csr(CSR_WINDOW, 0);
      write_csr(CSR_DIVISIONS, 0);
      write_csr(CSR_COHERENCY, 0);
      write_csr(CSR_CAPACITY, 0);
      arrival(clock_ms + 1);
      verify(clock_ms + 2, 100, 3);
      drain();
      set_profile(2);
      window_run(6);

      // random windows under several settings; calm stretch in the middle
      for (int phase = 0; phase < 12; phase++) begin
         drain();
         set_profile(phase < 2 ? phase + 2 : 3);
         calm = (phase == 5);
         for (int w = 0; w < 12; w++) window_run($urandom_range(15));
      end
      calm = 1'b0;

      drain();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
hdl/usla_pkg.sv
hdl/usla_chan_if.sv
hdl/usla_mul.sv
hdl/usla_div.sv
hdl/usl_worker_autoscaler.sv
test/tb.sv
